@@ src/frg_pkg.sv @@
// ----------------------------------------------------------------------------
// frg_pkg
// shared types and constants of the fragment reassembler
// ----------------------------------------------------------------------------
`default_nettype none

package frg_pkg;

	// frame buffer size in bytes and longest datagram that is looked at
	localparam int FRAME_BYTES  = 2048;
	localparam int MAX_DATAGRAM = 512;

	// header layout: 8 sequence bytes, 2 offset bytes, 2 length bytes
	localparam int SEQ_END   = 8;
	localparam int OFF_END   = 10;
	localparam int HDR_BYTES = 12;

	localparam int ADDR_W = 11;
	localparam int IDX_W  = 10;
	localparam int SEQ_W  = 64;
	localparam int HW_W   = 16;

	// byte position saturates here
	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} frg_in_t;

	typedef struct packed {
		logic              wr_valid;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              frame_done;
		logic [SEQ_W-1:0]  frame_sequence;
	} frg_out_t;

endpackage

`default_nettype wire

@@ src/frg_in_stage.sv @@
// ----------------------------------------------------------------------------
// frg_in_stage
// input register with a skid entry so the input stall is registered
// ----------------------------------------------------------------------------
`default_nettype none

module frg_in_stage import frg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire frg_in_t in_data,
	input  wire logic    take,
	output logic         item_valid,
	output frg_in_t      item
);

	logic    s1_valid_s1;
	frg_in_t item_s1;
	logic    skid_valid_q;
	frg_in_t skid_q;
	logic    accept;
	logic    s1_free;

	assign in_stall   = skid_valid_q;
	assign accept     = in_valid && !skid_valid_q;
	assign s1_free    = !s1_valid_s1 || take;
	assign item_valid = s1_valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (s1_free) begin
			if (skid_valid_q) begin
				s1_valid_s1  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				s1_valid_s1 <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			if (skid_valid_q) begin
				item_s1 <= skid_q;
			end else if (accept) begin
				item_s1 <= in_data;
			end
		end else if (accept) begin
			skid_q <= in_data;
		end
	end

	// skid entry only fills behind a held stage-one item
	a_skid_behind_s1: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> s1_valid_s1)
		else $error("skid entry valid while stage one empty");

endmodule

`default_nettype wire

@@ src/frg_core.sv @@
// ----------------------------------------------------------------------------
// frg_core
// header capture, fragment acceptance, write addressing and completion
// ----------------------------------------------------------------------------
`default_nettype none

module frg_core import frg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    play_enable,
	input  wire logic    item_valid,
	input  wire frg_in_t item,
	input  wire logic    out_ready,
	output logic         take,
	output logic         res_valid,
	output frg_out_t     res
);

	logic [IDX_W-1:0] byte_idx_q;
	logic [SEQ_W-1:0] hdr_seq_q;
	logic [HW_W-1:0]  hdr_off_q;
	logic [HW_W-1:0]  hdr_len_q;
	logic [SEQ_W-1:0] exp_seq_q;
	logic [HW_W-1:0]  exp_off_q;
	logic             frag_acc_q;
	logic [HW_W-1:0]  wbase_q;

	logic [IDX_W-1:0] pos;
	logic             in_range;
	logic [HW_W-1:0]  hdr_len_new;
	logic [SEQ_W-1:0] exp_seq_mid;
	logic [HW_W-1:0]  exp_off_mid;
	logic             frag_acc_mid;
	logic [HW_W-1:0]  wbase_mid;
	logic [IDX_W-1:0] pay_pos;
	logic [HW_W:0]    addr;
	logic             wr_hit;
	logic             complete;
	logic             done;

	assign pos         = byte_idx_q;
	assign in_range    = {1'b0, pos} < (IDX_W+1)'(MAX_DATAGRAM);
	assign hdr_len_new = {hdr_len_q[7:0], item.in_byte};
	assign pay_pos     = pos - IDX_W'(HDR_BYTES);
	assign addr        = {1'b0, wbase_q} + (HW_W+1)'(pay_pos);

	// acceptance on the last header byte
	always_comb begin
		exp_seq_mid  = exp_seq_q;
		exp_off_mid  = exp_off_q;
		frag_acc_mid = frag_acc_q;
		wbase_mid    = wbase_q;
		if (pos == IDX_W'(HDR_BYTES - 1)) begin
			if (hdr_off_q == '0) begin
				exp_seq_mid  = hdr_seq_q;
				wbase_mid    = '0;
				exp_off_mid  = hdr_len_new;
				frag_acc_mid = 1'b1;
			end else if (hdr_seq_q == exp_seq_q && hdr_off_q == exp_off_q) begin
				wbase_mid    = exp_off_q;
				exp_off_mid  = exp_off_q + hdr_len_new;
				frag_acc_mid = 1'b1;
			end else begin
				frag_acc_mid = 1'b0;
			end
		end
	end

	// payload write
	assign wr_hit = in_range && pos >= IDX_W'(HDR_BYTES) && frag_acc_q
		&& (HW_W'(pay_pos) < hdr_len_q) && (addr < (HW_W+1)'(FRAME_BYTES));

	assign complete = item.in_last && frag_acc_mid && (exp_off_mid == HW_W'(FRAME_BYTES));
	assign done     = complete && play_enable;

	always_comb begin
		res                = '0;
		res.wr_valid       = wr_hit;
		res.wr_addr        = wr_hit ? addr[ADDR_W-1:0] : '0;
		res.wr_data        = wr_hit ? item.in_byte : '0;
		res.frame_done     = done;
		res.frame_sequence = done ? exp_seq_mid : '0;
	end

	assign res_valid = wr_hit || done;
	assign take      = item_valid && (!res_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			hdr_seq_q  <= '0;
			hdr_off_q  <= '0;
			hdr_len_q  <= '0;
			exp_seq_q  <= '0;
			exp_off_q  <= '0;
			frag_acc_q <= 1'b0;
			wbase_q    <= '0;
		end else if (take) begin
			if (pos < IDX_W'(SEQ_END)) begin
				hdr_seq_q <= {hdr_seq_q[SEQ_W-9:0], item.in_byte};
			end else if (pos < IDX_W'(OFF_END)) begin
				hdr_off_q <= {hdr_off_q[7:0], item.in_byte};
			end else if (pos < IDX_W'(HDR_BYTES)) begin
				hdr_len_q <= hdr_len_new;
			end
			exp_seq_q <= exp_seq_mid;
			wbase_q   <= wbase_mid;
			if (item.in_last) begin
				exp_off_q  <= complete ? '0 : exp_off_mid;
				frag_acc_q <= 1'b0;
				byte_idx_q <= '0;
			end else begin
				exp_off_q  <= exp_off_mid;
				frag_acc_q <= frag_acc_mid;
				if (byte_idx_q != IDX_MAX) begin
					byte_idx_q <= byte_idx_q + 1'b1;
				end
			end
		end
	end

	a_done_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.frame_done |-> play_enable)
		else $error("frame done while playback disabled");

	a_write_past_header: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.wr_valid |-> byte_idx_q >= IDX_W'(HDR_BYTES))
		else $error("write issued from a header byte");

	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.in_last |=> byte_idx_q == '0 && !frag_acc_q)
		else $error("datagram end did not rewind position");

	a_done_clears_off: assert property (@(posedge clk) disable iff (!arst_n)
		take && res.frame_done |=> exp_off_q == '0)
		else $error("expected offset not cleared after completion");

endmodule

`default_nettype wire

@@ src/fragment_reassembler.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembler
// rebuilds a frame from sequence/offset numbered datagram fragments
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in       | into      | in_valid / in_stall  | in_data   (frg_in_t)
//  out      | out of    | out_valid / out_stall| out_data  (frg_out_t)
//  cfg      | into      | cfg_wr_en            | cfg_wr_data (play_enable)
//
//  one request per cycle sustained while out_stall is low; a request goes from the input
//  register to the result register, with one byte decoded in between
//  bytes that produce no write and no completion leave no result
//  reset clears position, header, expected sequence/offset and play_enable
//  in_stall rises only when the skid entry holds a request, so it never
//  follows out_stall in the same cycle; a stalled result holds its register
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembler import frg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_wr_en,
	input  wire logic    cfg_wr_data,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire frg_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_stall,
	output frg_out_t     out_data
);

	logic     play_enable_q;
	logic     item_valid;
	frg_in_t  item;
	logic     take;
	logic     res_valid;
	frg_out_t res;
	logic     out_ready;
	logic     out_valid_q;
	frg_out_t out_data_q;

	// playback gate; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			play_enable_q <= cfg_wr_data;
		end
	end

	// input register plus skid entry
	frg_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.take      (take),
		.item_valid(item_valid),
		.item      (item)
	);

	// per-byte decode and state update
	frg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.play_enable(play_enable_q),
		.item_valid (item_valid),
		.item       (item),
		.out_ready  (out_ready),
		.take       (take),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register: reloads when empty or being drained
	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && take && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
